@@ src/peu_pkg.sv @@
// ----------------------------------------------------------------------------
// peu_pkg
// Shared constants, register codes and controller/datapath bundles for the
// particle emitter update block.
// ----------------------------------------------------------------------------
package peu_pkg;

	// store depth default
	localparam int MAX_PARTICLES_DEF = 32;

	// field widths
	localparam int TIME_W    = 24;
	localparam int ACC_W     = 25;
	localparam int POS_W     = 32;
	localparam int LIFE_W    = 19;
	localparam int SLOT_W    = 5;
	localparam int CFG_W     = 32;
	localparam int REG_IDX_W = 2;

	// lifetime of a fresh particle, 5 s in Q3.16
	localparam logic [LIFE_W-1:0] LIFE_START = 19'd327680;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_SPAWN_INTERVAL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_EMITTER_X      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_EMITTER_Y      = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_EMITTER_Z      = 2'd3;

	// one stored particle
	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
		logic [LIFE_W-1:0] life;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic chk_pass;
		logic div_start;
		logic div_fin;
		logic upd_run;
		logic upd_fin;
		logic emit_rd;
		logic emit_ld;
		logic emit_empty;
		logic emit_next;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic a_gt;
		logic div_done;
		logic upd_done;
		logic live_zero;
		logic out_last;
	} sts_t;

endpackage

@@ src/peu_if.sv @@
// ----------------------------------------------------------------------------
// peu_if
// Valid/ready channels: tick beats in, particle result beats out.
// ----------------------------------------------------------------------------
interface peu_tick_if;
	logic                         valid;
	logic                         ready;
	logic [peu_pkg::TIME_W-1:0]   elapsed_time;

	modport source (output valid, output elapsed_time, input ready);
	modport sink (input valid, input elapsed_time, output ready);
endinterface

interface peu_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [peu_pkg::POS_W-1:0]  pos_x;
	logic signed [peu_pkg::POS_W-1:0]  pos_y;
	logic signed [peu_pkg::POS_W-1:0]  pos_z;
	logic [peu_pkg::LIFE_W-1:0]        life_left;
	logic [peu_pkg::SLOT_W-1:0]        slot;
	logic                              empty_res;
	logic                              last;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output life_left, output slot, output empty_res, output last, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input life_left, input slot, input empty_res, input last, output ready);
endinterface

@@ src/peu_div.sv @@
// ----------------------------------------------------------------------------
// peu_div
// Restoring divider, one quotient bit per cycle, for the spawn count and
// the leftover accumulator time.
// ----------------------------------------------------------------------------
module peu_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [peu_pkg::ACC_W-1:0]    dividend,
	input  logic [peu_pkg::TIME_W-1:0]   divisor,
	output logic                         done,
	output logic [peu_pkg::ACC_W-1:0]    quo,
	output logic [peu_pkg::TIME_W-1:0]   rem
);
	import peu_pkg::*;

	localparam int CNT_W = $clog2(ACC_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] dq_q;
	logic [TIME_W-1:0] rem_q;

	logic [ACC_W-1:0] trial;
	logic             ge;
	logic [ACC_W-1:0] diff;

	// one shift-subtract step
	always_comb begin
		trial = {rem_q, dq_q[ACC_W-1]};
		ge    = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[ACC_W-2:0], ge};
			rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = dq_q;
	assign rem  = rem_q;

endmodule

@@ src/peu_ctrl.sv @@
// ----------------------------------------------------------------------------
// peu_ctrl
// Tick sequencer: accumulate, divide, update/compact pass, emit pass.
// ----------------------------------------------------------------------------
module peu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  peu_pkg::sts_t  sts,
	output peu_pkg::cmd_t  cmd
);
	import peu_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_LD   = 3'd5;
	localparam logic [2:0] ST_WAIT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// next state and commands
	always_comb begin
		state_nx  = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.a_gt) begin
					cmd.div_start = 1'b1;
					state_nx      = ST_DIV;
				end else begin
					cmd.chk_pass = 1'b1;
					state_nx     = ST_UPD;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.div_fin = 1'b1;
					state_nx    = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd_run = 1'b1;
				if (sts.upd_done) begin
					cmd.upd_fin = 1'b1;
					state_nx    = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.live_zero) begin
					cmd.emit_empty = 1'b1;
					state_nx       = ST_WAIT;
				end else begin
					cmd.emit_rd = 1'b1;
					state_nx    = ST_LD;
				end
			end
			ST_LD: begin
				cmd.emit_ld = 1'b1;
				state_nx    = ST_WAIT;
			end
			ST_WAIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.out_last) begin
						state_nx = ST_IDLE;
					end else begin
						cmd.emit_next = 1'b1;
						state_nx      = ST_LD;
					end
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

@@ src/peu_dp.sv @@
// ----------------------------------------------------------------------------
// peu_dp
// Datapath: configuration registers, spawn accumulator, particle store,
// update/compact stage and result register.
// ----------------------------------------------------------------------------
module peu_dp #(
	parameter int MAX_PARTICLES = peu_pkg::MAX_PARTICLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  peu_pkg::cmd_t                     cmd,
	output peu_pkg::sts_t                     sts,
	input  logic [peu_pkg::TIME_W-1:0]        elapsed_time,
	input  logic                              wr_en,
	input  logic [peu_pkg::REG_IDX_W-1:0]     wr_idx,
	input  logic [peu_pkg::CFG_W-1:0]         wr_data,
	output logic signed [peu_pkg::POS_W-1:0]  pos_x,
	output logic signed [peu_pkg::POS_W-1:0]  pos_y,
	output logic signed [peu_pkg::POS_W-1:0]  pos_z,
	output logic [peu_pkg::LIFE_W-1:0]        life_left,
	output logic [peu_pkg::SLOT_W-1:0]        slot,
	output logic                              empty_res,
	output logic                              last
);
	import peu_pkg::*;

	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

	// configuration
	logic [TIME_W-1:0] spawn_interval_q;
	logic [POS_W-1:0]  emitter_x_q;
	logic [POS_W-1:0]  emitter_y_q;
	logic [POS_W-1:0]  emitter_z_q;

	// tick state
	logic [ACC_W-1:0]  accum_q;
	logic [ACC_W-1:0]  a_q;
	logic [TIME_W-1:0] dt_q;
	logic [CW-1:0]     live_q;
	logic [CW-1:0]     total_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     w_q;

	// store and read register
	entry_t            mem_q [MAX_PARTICLES];
	entry_t            rd_q;
	logic              v_s1;
	logic              spawn_s1;

	// result register
	entry_t            out_q;
	logic [SLOT_W-1:0] slot_q;
	logic              empty_q;
	logic              last_q;

	logic [TIME_W-1:0] ival;
	logic [ACC_W-1:0]  quo;
	logic [TIME_W-1:0] rem;
	logic              div_done;
	logic [CW-1:0]     idx_nx;
	logic [CW-1:0]     room;
	logic              upd_rd;
	logic              upd_wr;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	entry_t            e_cur;
	entry_t            e_new;
	logic [26:0]       dt5;
	logic [33:0]       y_full;
	logic [ACC_W-1:0]  life_full;
	logic              keep;

	// zero interval acts as the smallest interval
	assign ival = (spawn_interval_q == '0) ? TIME_W'(1) : spawn_interval_q;

	peu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (a_q - ACC_W'(1)),
		.divisor  (ival),
		.done     (div_done),
		.quo      (quo),
		.rem      (rem)
	);

	// free slots left in the store
	assign room   = CW'(MAX_PARTICLES) - live_q;
	assign idx_nx = idx_q + 1'b1;

	// update pass reads
	assign upd_rd  = cmd.upd_run && (idx_q < total_q);
	assign rd_en   = upd_rd || cmd.emit_rd || cmd.emit_next;
	assign rd_addr = cmd.emit_next ? idx_nx[AW-1:0] : idx_q[AW-1:0];

	// move one particle: fresh ones come from the emitter
	always_comb begin
		if (spawn_s1) begin
			e_cur.x    = emitter_x_q;
			e_cur.y    = emitter_y_q;
			e_cur.z    = emitter_z_q;
			e_cur.life = LIFE_START;
		end else begin
			e_cur = rd_q;
		end
		dt5       = {1'b0, dt_q, 2'b00} + {3'b000, dt_q};
		y_full    = {{2{e_cur.y[POS_W-1]}}, e_cur.y} - {7'b0, dt5};
		life_full = {6'b0, e_cur.life} - {1'b0, dt_q};
		keep      = !life_full[ACC_W-1] && (life_full != '0);
		e_new.x   = e_cur.x;
		e_new.z   = e_cur.z;
		e_new.life = life_full[LIFE_W-1:0];
		// saturate at the most negative position
		if (y_full[33] && (y_full[32:31] != 2'b11)) begin
			e_new.y = 32'h8000_0000;
		end else begin
			e_new.y = y_full[POS_W-1:0];
		end
	end

	assign upd_wr = v_s1 && keep;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spawn_interval_q <= TIME_W'(6554);
			emitter_x_q      <= '0;
			emitter_y_q      <= '0;
			emitter_z_q      <= '0;
			accum_q          <= '0;
			live_q           <= '0;
			idx_q            <= '0;
			w_q              <= '0;
			v_s1             <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_idx)
					REG_SPAWN_INTERVAL: spawn_interval_q <= wr_data[TIME_W-1:0];
					REG_EMITTER_X:      emitter_x_q      <= wr_data;
					REG_EMITTER_Y:      emitter_y_q      <= wr_data;
					REG_EMITTER_Z:      emitter_z_q      <= wr_data;
					default:            ;
				endcase
			end
			if (cmd.load) begin
				idx_q <= '0;
				w_q   <= '0;
			end
			if (cmd.chk_pass) begin
				accum_q <= a_q;
			end
			if (cmd.div_fin) begin
				accum_q <= {1'b0, rem} + ACC_W'(1);
			end
			if (upd_rd) begin
				idx_q <= idx_nx;
			end
			v_s1 <= upd_rd;
			if (upd_wr) begin
				w_q <= w_q + 1'b1;
			end
			if (cmd.upd_fin) begin
				live_q <= w_q;
				idx_q  <= '0;
			end
			if (cmd.emit_next) begin
				idx_q <= idx_nx;
			end
		end
	end

	// tick payload and particle count after spawning
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dt_q <= elapsed_time;
			a_q  <= accum_q + {1'b0, elapsed_time};
		end
		if (cmd.chk_pass) begin
			total_q <= live_q;
		end
		if (cmd.div_fin) begin
			if (quo >= ACC_W'(room)) begin
				total_q <= CW'(MAX_PARTICLES);
			end else begin
				total_q <= live_q + quo[CW-1:0];
			end
		end
		if (upd_rd) begin
			spawn_s1 <= idx_q >= live_q;
		end
	end

	// particle store: one write, one registered read
	always_ff @(posedge clk) begin
		if (upd_wr) begin
			mem_q[w_q[AW-1:0]] <= e_new;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_q   <= rd_q;
			slot_q  <= SLOT_W'(idx_q);
			empty_q <= 1'b0;
			last_q  <= idx_q == (live_q - 1'b1);
		end else if (cmd.emit_empty) begin
			out_q   <= '0;
			slot_q  <= '0;
			empty_q <= 1'b1;
			last_q  <= 1'b1;
		end
	end

	// status
	always_comb begin
		sts.a_gt      = a_q > {1'b0, ival};
		sts.div_done  = div_done;
		sts.upd_done  = (idx_q == total_q) && !v_s1;
		sts.live_zero = live_q == '0;
		sts.out_last  = last_q;
	end

	assign pos_x     = out_q.x;
	assign pos_y     = out_q.y;
	assign pos_z     = out_q.z;
	assign life_left = out_q.life;
	assign slot      = slot_q;
	assign empty_res = empty_q;
	assign last      = last_q;

endmodule

@@ src/particle_emitter_update_top.sv @@
// Sequence: a tick is loaded and the accumulator checked; when it passes the interval,
// the divider works out the spawn count and leftover time, one quotient bit per cycle.
// The update pass covers the particles after spawning, then the emit pass loads each
// beat into the result register and offers it until ready (one void beat when none).
// One tick at a time: the next tick can be taken the cycle after the last beat
// is taken. Reset: state, divider control, configuration, accumulator and counters
// reset at once (interval to 6554); store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// particle_emitter_update_top
// Particle emitter tick: spawn, move, age, compact and stream live particles.
// ----------------------------------------------------------------------------
module particle_emitter_update_top #(
	parameter int MAX_PARTICLES = peu_pkg::MAX_PARTICLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	peu_tick_if.sink                        tick,
	peu_result_if.source                    result,
	input  logic                            wr_en,
	input  logic [peu_pkg::REG_IDX_W-1:0]   wr_idx,
	input  logic [peu_pkg::CFG_W-1:0]       wr_data
);
	import peu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	peu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	peu_dp #(
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.elapsed_time (tick.elapsed_time),
		.wr_en        (wr_en),
		.wr_idx       (wr_idx),
		.wr_data      (wr_data),
		.pos_x        (result.pos_x),
		.pos_y        (result.pos_y),
		.pos_z        (result.pos_z),
		.life_left    (result.life_left),
		.slot         (result.slot),
		.empty_res    (result.empty_res),
		.last         (result.last)
	);

	// a tick beat starts work, so no second tick is taken right after
	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> !tick.ready)
		else $error("tick taken while previous tick in progress");

	// the void result is always the only one
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.empty_res |-> result.last)
		else $error("empty result not marked last");

	// compaction leaves only particles with lifetime left
	a_live_has_life: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.empty_res |-> result.life_left != '0)
		else $error("dead particle emitted");

	// after the last beat the block is ready for a new tick
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.last |=> tick.ready && !result.valid)
		else $error("not ready after final result");

endmodule

@@ tb/tb_particle_emitter_update_top.sv @@
// ----------------------------------------------------------------------------
// tb_particle_emitter_update_top
// Self-checking bench for the particle emitter tick. Tick beats go in over a
// valid/ready channel. A predictor keeps its own copy of the store, the spawn
// accumulator and the emitter registers, and queues the particle beats that
// each accepted tick should produce. A checker compares every result beat,
// field by field, with the oldest queued beat. Directed ticks hit the
// extremes first: empty store, exact expiry, full store, zero interval and
// saturation. Back-pressure and random phases over several register settings
// follow.
// ----------------------------------------------------------------------------
module tb_particle_emitter_update_top;
	import peu_pkg::*;

	localparam int           STORE_DEPTH = MAX_PARTICLES_DEF;
	localparam int           IDLE_PCT    = 31;
	localparam int           HOLD_CYCLES = 600;
	localparam longint       Y_FLOOR     = -64'sd2147483648;
	localparam logic [31:0]  POS_MIN     = 32'h8000_0000;
	localparam logic [31:0]  POS_MAX     = 32'h7fff_ffff;
	localparam logic [23:0]  TIME_MAX    = 24'hff_ffff;

	// one particle beat as seen on the result channel
	typedef struct {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [LIFE_W-1:0]       life;
		logic [SLOT_W-1:0]       slot;
		logic                    empty;
		logic                    last;
	} beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_idx;
	logic [CFG_W-1:0]     wr_data;

	// receiver control
	logic hold_ready;
	logic steady;

	int mismatches;

	peu_tick_if   tick_ch ();
	peu_result_if res_ch ();

	particle_emitter_update_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.result  (res_ch),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	always #5 clk = ~clk;

	// predictor state: emitter registers, particle store, accumulator
	logic [TIME_W-1:0]       spawn_gap;
	logic signed [POS_W-1:0] emit_x, emit_y, emit_z;
	logic signed [POS_W-1:0] part_x [STORE_DEPTH];
	logic signed [POS_W-1:0] part_y [STORE_DEPTH];
	logic signed [POS_W-1:0] part_z [STORE_DEPTH];
	logic [LIFE_W-1:0]       part_life [STORE_DEPTH];
	int unsigned             live_parts;
	logic [ACC_W-1:0]        spawn_acc;

	beat_t particle_beats_due[$];

	function automatic void clear_emitter_model();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			part_x[i] = '0;
			part_y[i] = '0;
			part_z[i] = '0;
			part_life[i] = '0;
		end
		live_parts = 0;
		spawn_acc = '0;
		spawn_gap = 24'd6554;
		emit_x = '0;
		emit_y = '0;
		emit_z = '0;
	endfunction

	// spawn, fall, age and compact for one tick, then queue the beats it yields
	function automatic void advance_particles(input logic [TIME_W-1:0] dt);
		int unsigned gap;
		int unsigned acc;
		int unsigned births;
		int unsigned keep;
		longint      y_new;
		longint      life_new;
		beat_t       b;
		gap = (spawn_gap == '0) ? 1 : int'(spawn_gap);
		acc = int'(spawn_acc) + int'(dt);
		births = 0;
		if (acc > gap) begin
			births = (acc - 1) / gap;
			acc = acc - births * gap;
		end
		spawn_acc = ACC_W'(acc);

		// new particles at the emitter, dropped once the store is full
		while (births > 0 && live_parts < STORE_DEPTH) begin
			part_x[live_parts] = emit_x;
			part_y[live_parts] = emit_y;
			part_z[live_parts] = emit_z;
			part_life[live_parts] = LIFE_START;
			live_parts++;
			births--;
		end

		// move down at 5 units/s, age, drop the dead and close the gaps
		keep = 0;
		for (int i = 0; i < live_parts; i++) begin
			y_new = longint'(part_y[i]) - 64'sd5 * longint'(dt);
			life_new = longint'(part_life[i]) - longint'(dt);
			if (y_new < Y_FLOOR)
				y_new = Y_FLOOR;
			if (life_new > 0) begin
				part_x[keep] = part_x[i];
				part_y[keep] = POS_W'(y_new);
				part_z[keep] = part_z[i];
				part_life[keep] = LIFE_W'(life_new);
				keep++;
			end
		end
		live_parts = keep;

		// stream the survivors, or one void beat when nothing is live
		if (live_parts == 0) begin
			b = '{x: '0, y: '0, z: '0, life: '0, slot: '0, empty: 1'b1, last: 1'b1};
			particle_beats_due.insert(particle_beats_due.size(), b);
		end else begin
			for (int i = 0; i < live_parts; i++) begin
				b.x = part_x[i];
				b.y = part_y[i];
				b.z = part_z[i];
				b.life = part_life[i];
				b.slot = SLOT_W'(i);
				b.empty = 1'b0;
				b.last = (i + 1 == live_parts);
				particle_beats_due.insert(particle_beats_due.size(), b);
			end
		end
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endfunction

	// receiver ready: random stalls, a no-stall stretch and a long hold-off
	always @(posedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else if (hold_ready)
			res_ch.ready <= 1'b0;
		else if (steady)
			res_ch.ready <= 1'b1;
		else
			res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
	end

	// compare each result beat with the oldest queued particle beat
	always @(posedge clk) begin : result_check
		beat_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (particle_beats_due.size() == 0) begin
				mismatches++;
				$display("%0t: beat expected none, got slot %0d empty %b last %b",
					$time, res_ch.slot, res_ch.empty_res, res_ch.last);
			end else begin
				want = particle_beats_due.pop_front();
				check_field("pos_x", want.x, res_ch.pos_x);
				check_field("pos_y", want.y, res_ch.pos_y);
				check_field("pos_z", want.z, res_ch.pos_z);
				check_field("life_left", 32'(want.life), 32'(res_ch.life_left));
				check_field("slot", 32'(want.slot), 32'(res_ch.slot));
				check_field("empty_res", 32'(want.empty), 32'(res_ch.empty_res));
				check_field("last", 32'(want.last), 32'(res_ch.last));
			end
		end
	end

	// offer one tick beat, with a random gap ahead of it, and predict on accept
	task automatic send_tick(input logic [TIME_W-1:0] dt);
		int gap;
		gap = 0;
		while (!steady && $urandom_range(99) < IDLE_PCT)
			gap++;
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.elapsed_time <= dt;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		advance_particles(dt);
	endtask

	// drop valid and wait until every queued beat has come out
	task automatic wait_idle();
		tick_ch.valid <= 1'b0;
		while (particle_beats_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= data;
		case (idx)
			REG_SPAWN_INTERVAL: spawn_gap = data[TIME_W-1:0];
			REG_EMITTER_X:      emit_x = data;
			REG_EMITTER_Y:      emit_y = data;
			REG_EMITTER_Z:      emit_z = data;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_emitter(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] ex,
			input logic [CFG_W-1:0] ey, input logic [CFG_W-1:0] ez);
		wait_idle();
		write_reg(REG_SPAWN_INTERVAL, gap);
		write_reg(REG_EMITTER_X, ex);
		write_reg(REG_EMITTER_Y, ey);
		write_reg(REG_EMITTER_Z, ez);
	endtask

	function automatic logic [TIME_W-1:0] random_dt();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		else if (pick < 18)
			return TIME_W'($urandom);
		else if (pick < 35)
			return TIME_W'($urandom_range(120000, 10000));
		else
			return TIME_W'($urandom_range(8000, 1));
	endfunction

	// reset register values: empty store, just below and just over one interval
	task automatic test_reset_defaults();
		send_tick(24'd0);
		send_tick(24'd6553);
		send_tick(24'd2);
		send_tick(24'd0);
	endtask

	// a spawn burst that expires exactly, then the longest step
	task automatic test_exact_expiry();
		send_tick(24'd327680);
		send_tick(TIME_MAX);
	endtask

	// shortest interval fills the store, extra spawns are dropped
	task automatic test_store_full();
		set_emitter(32'd1, 32'h0001_0000, 32'h0064_0000, 32'hffff_0000);
		send_tick(24'd100);
		send_tick(24'd0);
		send_tick(24'd1);
		send_tick(24'd5000);
	endtask

	// zero interval acts like the shortest one
	task automatic test_zero_interval();
		set_emitter(32'd0, POS_MAX, POS_MIN, 32'd0);
		send_tick(24'd3);
		send_tick(24'd1);
		send_tick(24'd327000);
	endtask

	// longest interval, emitter at the corners, y saturates at the floor
	task automatic test_saturation();
		set_emitter({8'd0, TIME_MAX}, POS_MAX, POS_MIN + 32'd3, POS_MIN);
		send_tick(TIME_MAX);
		send_tick(24'd10);
		send_tick(24'd1);
		set_emitter(32'd7, POS_MIN, POS_MAX, POS_MAX);
		send_tick(24'd20);
		send_tick(24'd300000);
	endtask

	// receiver holds off while ticks keep coming, so the block backs up
	task automatic test_backpressure();
		set_emitter(32'd2000, 32'h1234_5678, 32'h0000_0000, 32'h8765_4321);
		fork
			begin
				hold_ready <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_ready <= 1'b0;
			end
		join_none
		for (int i = 0; i < 12; i++)
			send_tick(TIME_W'($urandom_range(6000, 1500)));
	endtask

	// random ticks over several register settings, one phase without idling
	task automatic test_random_phases();
		logic [CFG_W-1:0] gap;
		logic [CFG_W-1:0] ey;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: gap = $urandom_range(50, 1);
				1: gap = $urandom_range(20000, 2000);
				2: gap = {8'd0, TIME_W'($urandom)};
				3: gap = 32'd3000;
				4: gap = $urandom_range(600, 0);
				default: gap = $urandom_range(9000, 200);
			endcase
			ey = (phase == 4) ? POS_MIN + $urandom_range(100000, 0) : $urandom;
			set_emitter(gap, $urandom, ey, $urandom);
			if (phase == 3)
				steady <= 1'b1;
			for (int i = 0; i < 50; i++)
				send_tick(random_dt());
			if (phase == 3)
				steady <= 1'b0;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		tick_ch.valid <= 1'b0;
		tick_ch.elapsed_time <= '0;
		wr_en <= 1'b0;
		wr_idx <= '0;
		wr_data <= '0;
		hold_ready <= 1'b0;
		steady <= 1'b0;
		mismatches = 0;
		clear_emitter_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_exact_expiry();
		test_store_full();
		test_zero_interval();
		test_saturation();
		test_backpressure();
		test_random_phases();

		// drain and let the block settle
		wait_idle();
		repeat (64) @(posedge clk);
		if (particle_beats_due.size() != 0) begin
			mismatches++;
			$display("%0t: beats left over expected 0, got %0d", $time,
				particle_beats_due.size());
		end
		if (mismatches == 0)
			$display("tb_particle_emitter_update_top: done, clean");
		else
			$display("tb_particle_emitter_update_top: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("tb_particle_emitter_update_top: done, errors");
		$finish;
	end

endmodule
